/* rtl/core/sca_pkg.sv */
// Shared constants, codes and types for the sound channel allocator.
package sca_pkg;

    localparam int CHANNELS = 8;
    localparam int SOUNDS   = 32;

    localparam int CH_W   = 3;
    localparam int SND_W  = 5;
    localparam int MODE_W = 3;
    localparam int MASK_W = 8;

    localparam logic [MODE_W-1:0] MODE_GRAB       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP_SND = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP_CH  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR_SND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR_CH   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESET      = 3'd5;

    localparam logic [CHANNELS-1:0] ALL_CHANNELS = {CHANNELS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_SCAN_CH,
        ST_SCAN_SND,
        ST_COMMIT
    } state_t;

endpackage

/* rtl/core/sca_if.sv */
// Request and response channel interfaces of the sound channel allocator.
interface sca_req_if;
    logic                       valid;
    logic                       ready;
    logic [sca_pkg::MODE_W-1:0] mode;
    logic [sca_pkg::SND_W-1:0]  sound_num;
    logic [sca_pkg::CH_W-1:0]   channel;
    logic [sca_pkg::MASK_W-1:0] playing_mask;

    modport source (output valid, mode, sound_num, channel, playing_mask, input ready);
    modport sink   (input valid, mode, sound_num, channel, playing_mask, output ready);
endinterface

interface sca_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [sca_pkg::CH_W-1:0]   channel_out;
    logic [sca_pkg::SND_W-1:0]  sound_out;
    logic [sca_pkg::MASK_W-1:0] free_mask_out;

    modport source (output valid, found, channel_out, sound_out, free_mask_out, input ready);
    modport sink   (input valid, found, channel_out, sound_out, free_mask_out, output ready);
endinterface

/* rtl/core/sound_channel_allocator_core.sv */
// Sound channel allocator: sound-to-channel and channel-to-sound maps under a small sequencer.
// The path from an accepted request beat to its response beat is set by the lookup: a
// direct map hit, a fallback search of the channel map channel by channel, or a fallback
// search of the sound map sound by sound through the map's single registered read port.
// Requests are taken one at a time; the next request is accepted no earlier than the
// cycle in which the response beat of the previous one leaves.
module sound_channel_allocator_core (
    input  logic      clk,
    input  logic      rst_n,
    sca_req_if.sink   req,
    sca_rsp_if.source rsp
);

    sca_pkg::state_t state_reg, state_next;

    logic [sca_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [sca_pkg::SND_W-1:0]    snd_reg, snd_next;
    logic [sca_pkg::CH_W-1:0]     ch_reg, ch_next;
    logic [sca_pkg::CHANNELS-1:0] play_reg, play_next;
    logic                         hit_reg, hit_next;
    logic [sca_pkg::CH_W-1:0]     c_reg, c_next;
    logic [sca_pkg::SND_W-1:0]    s_reg, s_next;
    logic [sca_pkg::SND_W-1:0]    idx_reg, idx_next;
    logic                         pend_reg, pend_next;
    logic [sca_pkg::SND_W-1:0]    pend_idx_reg, pend_idx_next;

    logic [sca_pkg::SOUNDS-1:0]   s2c_vld_reg, s2c_vld_next;
    logic [sca_pkg::CHANNELS-1:0] c2s_vld_reg, c2s_vld_next;
    logic [sca_pkg::SND_W-1:0]    c2s_snd_reg [sca_pkg::CHANNELS];
    logic [sca_pkg::SND_W-1:0]    c2s_snd_next [sca_pkg::CHANNELS];
    logic [sca_pkg::CHANNELS-1:0] free_reg, free_next;
    logic [sca_pkg::CH_W-1:0]     last_reg, last_next;

    logic                         out_vld_reg, out_vld_next;
    logic                         found_reg, found_next;
    logic [sca_pkg::CH_W-1:0]     ch_out_reg, ch_out_next;
    logic [sca_pkg::SND_W-1:0]    snd_out_reg, snd_out_next;

    logic [sca_pkg::CH_W-1:0]     s2c_mem [sca_pkg::SOUNDS];
    logic [sca_pkg::CH_W-1:0]     mem_q_reg;
    logic [sca_pkg::SND_W-1:0]    rd_addr;
    logic                         mem_we;

    logic [sca_pkg::CH_W-1:0]     pick;
    logic [sca_pkg::CH_W-1:0]     grab_ch;
    logic [sca_pkg::CHANNELS-1:0] grab_bit;
    logic [sca_pkg::CHANNELS-1:0] c_bit;
    logic [sca_pkg::CHANNELS-1:0] ch_bit;
    logic [sca_pkg::CH_W-1:0]     scan_ch;
    logic                         snd_ok;
    logic                         ch_ok;
    logic                         in_ready;

    sca_pick u_pick (
        .free_mask (free_reg),
        .playing   (play_reg),
        .last      (last_reg),
        .pick      (pick)
    );

    assign snd_ok   = int'(snd_reg) < sca_pkg::SOUNDS;
    assign ch_ok    = int'(ch_reg) < sca_pkg::CHANNELS;
    assign scan_ch  = idx_reg[sca_pkg::CH_W-1:0];
    assign grab_ch  = hit_reg ? c_reg : pick;
    assign in_ready = (state_reg == sca_pkg::ST_IDLE) && (!out_vld_reg || rsp.ready);
    assign rd_addr  = (state_reg == sca_pkg::ST_SCAN_SND) ? idx_reg : snd_reg;

    always_comb
    begin
        grab_bit = '0;
        grab_bit[grab_ch] = 1'b1;
        c_bit = '0;
        c_bit[c_reg] = 1'b1;
        ch_bit = '0;
        ch_bit[ch_reg] = 1'b1;
    end

    assign req.ready         = in_ready;
    assign rsp.valid         = out_vld_reg;
    assign rsp.found         = found_reg;
    assign rsp.channel_out   = ch_out_reg;
    assign rsp.sound_out     = snd_out_reg;
    assign rsp.free_mask_out = free_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        snd_next      = snd_reg;
        ch_next       = ch_reg;
        play_next     = play_reg;
        hit_next      = hit_reg;
        c_next        = c_reg;
        s_next        = s_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        s2c_vld_next  = s2c_vld_reg;
        c2s_vld_next  = c2s_vld_reg;
        c2s_snd_next  = c2s_snd_reg;
        free_next     = free_reg;
        last_next     = last_reg;
        out_vld_next  = out_vld_reg;
        found_next    = found_reg;
        ch_out_next   = ch_out_reg;
        snd_out_next  = snd_out_reg;
        mem_we        = 1'b0;

        if (rsp.valid && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            sca_pkg::ST_IDLE:
            begin
                if (req.valid && in_ready)
                begin
                    mode_next  = req.mode;
                    snd_next   = req.sound_num;
                    ch_next    = req.channel;
                    play_next  = req.playing_mask[sca_pkg::CHANNELS-1:0];
                    state_next = sca_pkg::ST_START;
                end
            end
            sca_pkg::ST_START:
            begin
                hit_next   = 1'b0;
                idx_next   = '0;
                pend_next  = 1'b0;
                state_next = sca_pkg::ST_COMMIT;
                case (mode_reg) inside
                    sca_pkg::MODE_GRAB, sca_pkg::MODE_LOOKUP_SND, sca_pkg::MODE_CLEAR_SND:
                    begin
                        if (snd_ok)
                        begin
                            state_next = s2c_vld_reg[snd_reg] ? sca_pkg::ST_READ
                                                              : sca_pkg::ST_SCAN_CH;
                        end
                    end
                    sca_pkg::MODE_LOOKUP_CH, sca_pkg::MODE_CLEAR_CH:
                    begin
                        if (ch_ok)
                        begin
                            if (c2s_vld_reg[ch_reg])
                            begin
                                hit_next = 1'b1;
                                s_next   = c2s_snd_reg[ch_reg];
                            end
                            else
                            begin
                                state_next = sca_pkg::ST_SCAN_SND;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = sca_pkg::ST_COMMIT;
                    end
                endcase
            end
            sca_pkg::ST_READ:
            begin
                hit_next   = 1'b1;
                c_next     = mem_q_reg;
                state_next = sca_pkg::ST_COMMIT;
            end
            sca_pkg::ST_SCAN_CH:
            begin
                if (c2s_vld_reg[scan_ch] && c2s_snd_reg[scan_ch] == snd_reg)
                begin
                    hit_next   = 1'b1;
                    c_next     = scan_ch;
                    state_next = sca_pkg::ST_COMMIT;
                end
                else if (scan_ch == sca_pkg::CH_W'(sca_pkg::CHANNELS - 1))
                begin
                    state_next = sca_pkg::ST_COMMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            sca_pkg::ST_SCAN_SND:
            begin
                pend_next     = 1'b1;
                pend_idx_next = idx_reg;
                idx_next      = idx_reg + 1'b1;
                if (pend_reg && s2c_vld_reg[pend_idx_reg] && mem_q_reg == ch_reg)
                begin
                    hit_next   = 1'b1;
                    s_next     = pend_idx_reg;
                    state_next = sca_pkg::ST_COMMIT;
                end
                else if (pend_reg && pend_idx_reg == sca_pkg::SND_W'(sca_pkg::SOUNDS - 1))
                begin
                    state_next = sca_pkg::ST_COMMIT;
                end
            end
            sca_pkg::ST_COMMIT:
            begin
                found_next   = 1'b0;
                ch_out_next  = '0;
                snd_out_next = '0;
                out_vld_next = 1'b1;
                state_next   = sca_pkg::ST_IDLE;
                unique case (mode_reg)
                    sca_pkg::MODE_GRAB:
                    begin
                        if (snd_ok)
                        begin
                            if (!hit_reg)
                            begin
                                last_next = pick;
                            end
                            free_next             = free_reg & ~grab_bit;
                            s2c_vld_next[snd_reg] = 1'b1;
                            mem_we                = 1'b1;
                            c2s_vld_next[grab_ch] = 1'b1;
                            c2s_snd_next[grab_ch] = snd_reg;
                            found_next            = 1'b1;
                            ch_out_next           = grab_ch;
                        end
                    end
                    sca_pkg::MODE_LOOKUP_SND:
                    begin
                        if (snd_ok && hit_reg)
                        begin
                            found_next  = 1'b1;
                            ch_out_next = c_reg;
                        end
                    end
                    sca_pkg::MODE_LOOKUP_CH:
                    begin
                        if (ch_ok && hit_reg)
                        begin
                            found_next   = 1'b1;
                            ch_out_next  = ch_reg;
                            snd_out_next = s_reg;
                        end
                    end
                    sca_pkg::MODE_CLEAR_SND:
                    begin
                        if (snd_ok)
                        begin
                            s2c_vld_next[snd_reg] = 1'b0;
                            if (hit_reg)
                            begin
                                c2s_vld_next[c_reg] = 1'b0;
                                free_next           = free_reg | c_bit;
                                found_next          = 1'b1;
                                ch_out_next         = c_reg;
                            end
                        end
                    end
                    sca_pkg::MODE_CLEAR_CH:
                    begin
                        if (ch_ok)
                        begin
                            c2s_vld_next[ch_reg] = 1'b0;
                            if (hit_reg)
                            begin
                                s2c_vld_next[s_reg] = 1'b0;
                                found_next          = 1'b1;
                                ch_out_next         = ch_reg;
                                snd_out_next        = s_reg;
                            end
                            free_next = free_reg | ch_bit;
                        end
                    end
                    sca_pkg::MODE_RESET:
                    begin
                        s2c_vld_next = '0;
                        c2s_vld_next = '0;
                        free_next    = sca_pkg::ALL_CHANNELS;
                        last_next    = '0;
                    end
                    default:
                    begin
                        found_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = sca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sca_pkg::ST_IDLE;
            pend_reg    <= 1'b0;
            s2c_vld_reg <= '0;
            c2s_vld_reg <= '0;
            free_reg    <= sca_pkg::ALL_CHANNELS;
            last_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            s2c_vld_reg <= s2c_vld_next;
            c2s_vld_reg <= c2s_vld_next;
            free_reg    <= free_next;
            last_reg    <= last_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        snd_reg      <= snd_next;
        ch_reg       <= ch_next;
        play_reg     <= play_next;
        hit_reg      <= hit_next;
        c_reg        <= c_next;
        s_reg        <= s_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        c2s_snd_reg  <= c2s_snd_next;
        found_reg    <= found_next;
        ch_out_reg   <= ch_out_next;
        snd_out_reg  <= snd_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            s2c_mem[snd_reg] <= grab_ch;
        end
        mem_q_reg <= s2c_mem[rd_addr];
    end

endmodule

/* rtl/core/sca_pick.sv */
// Channel choice for a grab: lowest free idle channel, then lowest idle, then steal.
module sca_pick (
    input  logic [sca_pkg::CHANNELS-1:0] free_mask,
    input  logic [sca_pkg::CHANNELS-1:0] playing,
    input  logic [sca_pkg::CH_W-1:0]     last,
    output logic [sca_pkg::CH_W-1:0]     pick
);

    logic [sca_pkg::CHANNELS-1:0] idle_free;
    logic [sca_pkg::CHANNELS-1:0] idle_any;
    logic [sca_pkg::CH_W-1:0]     first_free;
    logic [sca_pkg::CH_W-1:0]     first_idle;
    logic [sca_pkg::CH_W-1:0]     steal;

    always_comb
    begin
        idle_free  = free_mask & ~playing;
        idle_any   = ~playing;
        first_free = '0;
        first_idle = '0;
        for (int i = sca_pkg::CHANNELS - 1; i >= 0; i--)
        begin
            if (idle_free[i])
            begin
                first_free = sca_pkg::CH_W'(i);
            end
            if (idle_any[i])
            begin
                first_idle = sca_pkg::CH_W'(i);
            end
        end
        if (last == sca_pkg::CH_W'(sca_pkg::CHANNELS - 1))
        begin
            steal = '0;
        end
        else
        begin
            steal = last + 1'b1;
        end
        if (|idle_free)
        begin
            pick = first_free;
        end
        else if (|idle_any)
        begin
            pick = first_idle;
        end
        else
        begin
            pick = steal;
        end
    end

endmodule
